// ----- design/dnh_pkg.sv -----
package dnh_pkg;

   localparam int MAX_DIM   = 64;
   localparam int MAX_CELLS = 4096;
   localparam int CELL_AW   = $clog2(MAX_CELLS);

   // Shared serial divider widths.
   localparam int DIV_NUM_W = 50;
   localparam int DIV_DEN_W = 42;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [1:0] {
      REQ_POSITION  = 2'd0,
      REQ_DETECT    = 2'd1,
      REQ_NORMALIZE = 2'd2,
      REQ_READ      = 2'd3
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_CELL_SIZE  = 3'd2,
      CSR_GRID_X     = 3'd3,
      CSR_GRID_Y     = 3'd4,
      CSR_DWELL_STEP = 3'd5,
      CSR_MIN_DWELL  = 3'd6,
      CSR_UNUSED     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [15:0]        cluster_count;
      logic [11:0]        read_index;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  cell_byte;
      logic [41:0] activity_max;
      logic        is_outside;
   } rsp_payload_type;

endpackage

// ----- design/dnh_ram.sv -----
module dnh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/dnh_div.sv -----
module dnh_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dnh_pkg::DIV_NUM_W-1:0] dividend,
   input  logic [dnh_pkg::DIV_DEN_W-1:0] divisor,
   output logic                        done,
   output logic [dnh_pkg::DIV_NUM_W-1:0] quotient,
   output logic [dnh_pkg::DIV_DEN_W-1:0] remainder
);
   import dnh_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 ge;

   // One restoring step per cycle, most significant dividend bit first.
   assign rem_sh = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_NUM_W);
            quo_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= ge ? DIV_DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DIV_DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- design/dwell_normalized_heatmap_top.sv -----
// Grid heatmap engine. Each transfer on the req channel yields exactly one rsp transfer.
// Memories: a 4096 x 56 cell store (hit count, dwell) and a 4096 x 8 byte store.
// After reset both are swept to zero, one entry a cycle; req_stall is high during that
// sweep while csr writes are taken as usual. A detection outside the grid writes nothing;
// a position update runs two serial divisions for the cell coordinates, then a
// read-modify-write of the cell when the dwell grows. Normalize walks the first
// grid_x*grid_y cells (each size capped at 64) once for the activity maximum and, if it
// is nonzero, again to write the bytes; a cell without enough dwell takes no division,
// an eligible one one division in the first pass and up to two in the second.
// The block handles one item at a time; a finished result may wait in the rsp register
// while the next item is accepted.
module dwell_normalized_heatmap_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dnh_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dnh_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [dnh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dnh_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import dnh_pkg::*;

   localparam int CRAM_W = 56;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIVX, ST_DIVY, ST_POS_EVAL, ST_POS_WB, ST_DET_WB,
      ST_RD_WAIT, ST_N_RD, ST_N_MUL, ST_N_ACT, ST_N_ADIV, ST_N_BDIV, ST_N_NEXT, ST_DONE
   } state_type;

   state_type state_ff;

   // Configuration.
   logic signed [23:0] origin_x_ff, origin_y_ff;
   logic [15:0]        cell_size_ff, dwell_step_ff, min_dwell_ff;
   logic [6:0]         grid_x_ff, grid_y_ff;

   // Tracking state.
   logic signed [24:0] cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff, dy_ff;
   logic               outside_ff;
   logic [CELL_AW-1:0] cur_idx_ff;
   logic               neg_ff;

   logic [CELL_AW-1:0] clr_ff, walk_ff, last_ff;
   logic               pass_ff, ok_ff;
   logic [41:0]        prod_ff, max_ff, res_act_ff;
   logic [31:0]        dwell_ff;
   logic [7:0]         res_byte_ff;
   logic [15:0]        req_fields_count_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff;

   // Memory and divider ports.
   logic               cram_we, bram_we;
   logic [CELL_AW-1:0] cram_wa, cram_ra, bram_wa, bram_ra;
   logic [CRAM_W-1:0]  cram_wd, cram_rd;
   logic [7:0]         bram_wd, bram_rd;
   logic               div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num, div_quo;
   logic [DIV_DEN_W-1:0] div_den, div_rem;

   // Derived values.
   logic [6:0]         dim_x, dim_y;
   logic [15:0]        cs_eff;
   logic signed [24:0] dx, q_floor;
   logic [24:0]        mag_dx, mag_dy, q_mag;
   logic               x_out, y_out, pos_out, same;
   logic [13:0]        new_idx_w;
   logic [23:0]        c_hit;
   logic [31:0]        c_dwell;
   logic [24:0]        hit_sum;
   logic [32:0]        dwell_sum;
   logic [41:0]        act;
   logic [13:0]        n_cells;
   logic               accept;

   dnh_ram #(.WIDTH(CRAM_W), .DEPTH(MAX_CELLS)) u_cell_ram (
      .clock(clock), .wr_en(cram_we), .wr_addr(cram_wa), .wr_data(cram_wd),
      .rd_addr(cram_ra), .rd_data(cram_rd)
   );

   dnh_ram #(.WIDTH(8), .DEPTH(MAX_CELLS)) u_byte_ram (
      .clock(clock), .wr_en(bram_we), .wr_addr(bram_wa), .wr_data(bram_wd),
      .rd_addr(bram_ra), .rd_data(bram_rd)
   );

   dnh_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_quo), .remainder(div_rem)
   );

   assign dim_x  = (grid_x_ff > 7'(MAX_DIM)) ? 7'(MAX_DIM) : grid_x_ff;
   assign dim_y  = (grid_y_ff > 7'(MAX_DIM)) ? 7'(MAX_DIM) : grid_y_ff;
   assign cs_eff = (cell_size_ff == 16'd0) ? 16'd1 : cell_size_ff;

   assign accept  = req_valid && !req_stall;
   assign dx      = 25'(req_payload.pos_x) - 25'(origin_x_ff);
   assign mag_dx  = dx[24] ? 25'(-dx) : dx;
   assign mag_dy  = dy_ff[24] ? 25'(-dy_ff) : dy_ff;
   assign n_cells = dim_x * dim_y;

   // Floor division from magnitude quotient and remainder.
   assign q_mag   = div_quo[24:0];
   assign q_floor = neg_ff ? 25'(-q_mag - 25'(div_rem != '0)) : q_mag;

   assign x_out = cur_x_ff[24] || (cur_x_ff >= $signed({18'd0, dim_x}));
   assign y_out = cur_y_ff[24] || (cur_y_ff >= $signed({18'd0, dim_y}));
   assign new_idx_w = 14'(cur_y_ff[6:0] * dim_x) + 14'(cur_x_ff[6:0]);
   assign pos_out = x_out || y_out || (new_idx_w >= 14'(MAX_CELLS));
   assign same    = (cur_x_ff == prev_x_ff) && (cur_y_ff == prev_y_ff);

   assign c_hit     = cram_rd[55:32];
   assign c_dwell   = cram_rd[31:0];
   assign hit_sum   = {1'b0, c_hit} + 25'(req_fields_count_ff);
   assign dwell_sum = {1'b0, c_dwell} + 33'(dwell_step_ff);
   assign act       = div_quo[41:0];

   always_comb begin
      cram_we   = 1'b0;
      cram_wa   = cur_idx_ff;
      cram_wd   = cram_rd;
      cram_ra   = walk_ff;
      bram_we   = 1'b0;
      bram_wa   = walk_ff;
      bram_wd   = div_quo[7:0];
      bram_ra   = req_payload.read_index;
      div_start = 1'b0;
      div_num   = DIV_NUM_W'(mag_dx);
      div_den   = DIV_DEN_W'(cs_eff);
      unique case (state_ff)
         ST_CLEAR: begin
            cram_we = 1'b1;
            cram_wa = clr_ff;
            cram_wd = '0;
            bram_we = 1'b1;
            bram_wa = clr_ff;
            bram_wd = '0;
         end
         ST_IDLE: begin
            // A detection uses the current cell indexed with the present row stride.
            cram_ra = new_idx_w[CELL_AW-1:0];
            div_start = accept && (req_payload.req_type == REQ_POSITION);
         end
         ST_DIVX: begin
            div_start = div_done;
            div_num   = DIV_NUM_W'(mag_dy);
         end
         ST_POS_EVAL: begin
            cram_ra = new_idx_w[CELL_AW-1:0];
         end
         ST_POS_WB: begin
            cram_we = 1'b1;
            cram_wd = {c_hit, dwell_sum[32] ? 32'hFFFF_FFFF : dwell_sum[31:0]};
         end
         ST_DET_WB: begin
            cram_we = 1'b1;
            cram_wd = {hit_sum[24] ? 24'hFF_FFFF : hit_sum[23:0], c_dwell};
         end
         ST_N_ACT: begin
            div_start = ok_ff;
            div_num   = DIV_NUM_W'(prod_ff);
            div_den   = DIV_DEN_W'(dwell_ff);
         end
         ST_N_ADIV: begin
            div_start = div_done && pass_ff && (act != '0);
            div_num   = DIV_NUM_W'({act, 8'd0}) - DIV_NUM_W'(act);
            div_den   = max_ff;
         end
         ST_N_BDIV: begin
            bram_we = div_done;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         cell_size_ff  <= 16'd256;
         grid_x_ff     <= 7'd64;
         grid_y_ff     <= 7'd64;
         dwell_step_ff <= 16'd10;
         min_dwell_ff  <= 16'd10;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         cur_idx_ff    <= '0;
         outside_ff    <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_ORIGIN_X:   origin_x_ff   <= csr_wr_data;
               CSR_ORIGIN_Y:   origin_y_ff   <= csr_wr_data;
               CSR_CELL_SIZE:  cell_size_ff  <= csr_wr_data[15:0];
               CSR_GRID_X:     grid_x_ff     <= csr_wr_data[6:0];
               CSR_GRID_Y:     grid_y_ff     <= csr_wr_data[6:0];
               CSR_DWELL_STEP: dwell_step_ff <= csr_wr_data[15:0];
               CSR_MIN_DWELL:  min_dwell_ff  <= csr_wr_data[15:0];
               CSR_UNUSED: begin
               end
            endcase
         end
         // In ST_DONE the result register is reloaded below instead.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CELL_AW'(MAX_CELLS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  res_byte_ff         <= '0;
                  res_act_ff          <= '0;
                  req_fields_count_ff <= req_payload.cluster_count;
                  unique case (req_code_type'(req_payload.req_type))
                     REQ_POSITION: begin
                        prev_x_ff <= cur_x_ff;
                        prev_y_ff <= cur_y_ff;
                        neg_ff    <= dx[24];
                        dy_ff     <= 25'(req_payload.pos_y) - 25'(origin_y_ff);
                        state_ff  <= ST_DIVX;
                     end
                     REQ_DETECT: begin
                        cur_idx_ff <= new_idx_w[CELL_AW-1:0];
                        state_ff   <= outside_ff ? ST_DONE : ST_DET_WB;
                     end
                     REQ_NORMALIZE: begin
                        walk_ff <= '0;
                        pass_ff <= 1'b0;
                        max_ff  <= '0;
                        last_ff <= CELL_AW'(n_cells - 14'd1);
                        state_ff <= (n_cells == '0) ? ST_DONE : ST_N_RD;
                     end
                     REQ_READ: begin
                        state_ff <= ST_RD_WAIT;
                     end
                  endcase
               end
            end
            ST_DIVX: begin
               if (div_done) begin
                  cur_x_ff <= q_floor;
                  neg_ff   <= dy_ff[24];
                  state_ff <= ST_DIVY;
               end
            end
            ST_DIVY: begin
               if (div_done) begin
                  cur_y_ff <= q_floor;
                  state_ff <= ST_POS_EVAL;
               end
            end
            ST_POS_EVAL: begin
               outside_ff <= pos_out;
               cur_idx_ff <= new_idx_w[CELL_AW-1:0];
               state_ff   <= (same && !pos_out) ? ST_POS_WB : ST_DONE;
            end
            ST_POS_WB: begin
               state_ff <= ST_DONE;
            end
            ST_DET_WB: begin
               state_ff <= ST_DONE;
            end
            ST_RD_WAIT: begin
               res_byte_ff <= bram_rd;
               state_ff    <= ST_DONE;
            end
            ST_N_RD: begin
               state_ff <= ST_N_MUL;
            end
            ST_N_MUL: begin
               prod_ff  <= 42'(c_hit * 18'd256000);
               dwell_ff <= c_dwell;
               ok_ff    <= (c_dwell != '0) && (c_dwell >= 32'(min_dwell_ff));
               state_ff <= ST_N_ACT;
            end
            ST_N_ACT: begin
               state_ff <= ok_ff ? ST_N_ADIV : ST_N_NEXT;
            end
            ST_N_ADIV: begin
               if (div_done) begin
                  if (!pass_ff) begin
                     if (act > max_ff) begin
                        max_ff <= act;
                     end
                     state_ff <= ST_N_NEXT;
                  end else begin
                     state_ff <= (act != '0) ? ST_N_BDIV : ST_N_NEXT;
                  end
               end
            end
            ST_N_BDIV: begin
               if (div_done) begin
                  state_ff <= ST_N_NEXT;
               end
            end
            ST_N_NEXT: begin
               if (walk_ff == last_ff) begin
                  walk_ff <= '0;
                  if (!pass_ff && max_ff != '0) begin
                     pass_ff  <= 1'b1;
                     state_ff <= ST_N_RD;
                  end else begin
                     res_act_ff <= max_ff;
                     state_ff   <= ST_DONE;
                  end
               end else begin
                  walk_ff  <= walk_ff + 1'b1;
                  state_ff <= ST_N_RD;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_payload_ff.cell_byte    <= res_byte_ff;
                  rsp_payload_ff.activity_max <= res_act_ff;
                  rsp_payload_ff.is_outside   <= outside_ff;
                  state_ff                    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- dv/tb_dwell_normalized_heatmap_top.sv -----
module tb_dwell_normalized_heatmap_top;
   import dnh_pkg::*;

   localparam longint CYCLE_LIMIT = 6000000;
   localparam longint unsigned HIT_SAT   = 64'hFF_FFFF;
   localparam longint unsigned DWELL_SAT = 64'hFFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   dwell_normalized_heatmap_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // Mirror of the block's grid state and registers.
   longint unsigned cell_hits [MAX_CELLS];
   longint unsigned cell_dwell [MAX_CELLS];
   logic [7:0] cell_norm [MAX_CELLS];
   longint cur_x, cur_y;
   logic pos_outside;
   longint org_x, org_y;
   int unsigned cfg_cell, cfg_gx, cfg_gy, cfg_step, cfg_min_dwell;

   req_payload_type pending_req_q[$];
   rsp_payload_type expected_rsp_q[$];
   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   longint cycle_count = 0;

   function automatic longint sext24(logic [23:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q -= 1;
      return q;
   endfunction

   function automatic int unsigned dim_x();
      return cfg_gx > MAX_DIM ? MAX_DIM : cfg_gx;
   endfunction

   function automatic int unsigned dim_y();
      return cfg_gy > MAX_DIM ? MAX_DIM : cfg_gy;
   endfunction

   function automatic longint unsigned activity_of(int i, output bit ok);
      ok = cell_dwell[i] != 0 && cell_dwell[i] >= cfg_min_dwell;
      return ok ? (cell_hits[i] * 256000) / cell_dwell[i] : 0;
   endfunction

   function automatic void heatmap_predict(req_payload_type r);
      rsp_payload_type e;
      longint px, py, cs, idx;
      longint unsigned a, mx, n;
      bit ok;
      e = '0;
      case (req_code_type'(r.req_type))
         REQ_POSITION: begin
            cs = cfg_cell == 0 ? 1 : cfg_cell;
            px = cur_x;
            py = cur_y;
            cur_x = floor_div(sext24(r.pos_x) - org_x, cs);
            cur_y = floor_div(sext24(r.pos_y) - org_y, cs);
            idx = cur_y * dim_x() + cur_x;
            pos_outside = cur_x < 0 || cur_y < 0 || cur_x >= dim_x() || cur_y >= dim_y()
                          || idx >= MAX_CELLS;
            if (px == cur_x && py == cur_y && !pos_outside) begin
               a = cell_dwell[idx] + cfg_step;
               cell_dwell[idx] = a > DWELL_SAT ? DWELL_SAT : a;
            end
         end
         REQ_DETECT: begin
            idx = cur_y * dim_x() + cur_x;
            if (!pos_outside && idx < MAX_CELLS) begin
               a = cell_hits[idx] + r.cluster_count;
               cell_hits[idx] = a > HIT_SAT ? HIT_SAT : a;
            end
         end
         REQ_NORMALIZE: begin
            n = dim_x() * dim_y();
            if (n > MAX_CELLS) n = MAX_CELLS;
            mx = 0;
            for (int i = 0; i < n; i++) begin
               a = activity_of(i, ok);
               if (ok && a > mx) mx = a;
            end
            if (mx != 0) begin
               for (int i = 0; i < n; i++) begin
                  a = activity_of(i, ok);
                  if (ok && a > 0) cell_norm[i] = 8'((255 * a) / mx);
               end
            end
            e.activity_max = mx[41:0];
         end
         default: e.cell_byte = cell_norm[r.read_index];
      endcase
      e.is_outside = pos_outside;
      expected_rsp_q = {expected_rsp_q, e};
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Driver: a stalled transfer holds; the next item goes out after acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) heatmap_predict(req_payload);
         if (!req_valid || !req_stall) begin
            if (pending_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= pending_req_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_payload.cell_byte !== e.cell_byte)
                  report_mismatch("cell_byte", rsp_payload.cell_byte, e.cell_byte);
               if (rsp_payload.activity_max !== e.activity_max)
                  report_mismatch("activity_max", rsp_payload.activity_max, e.activity_max);
               if (rsp_payload.is_outside !== e.is_outside)
                  report_mismatch("is_outside", rsp_payload.is_outside, e.is_outside);
            end
         end
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_dwell_normalized_heatmap_top: done, errors");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_ORIGIN_X:   org_x = sext24(data);
         CSR_ORIGIN_Y:   org_y = sext24(data);
         CSR_CELL_SIZE:  cfg_cell = data[15:0];
         CSR_GRID_X:     cfg_gx = data[6:0];
         CSR_GRID_Y:     cfg_gy = data[6:0];
         CSR_DWELL_STEP: cfg_step = data[15:0];
         CSR_MIN_DWELL:  cfg_min_dwell = data[15:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(int ox, int oy, int cs, int gx, int gy, int step, int mind);
      csr_write(CSR_ORIGIN_X, ox[23:0]);
      csr_write(CSR_ORIGIN_Y, oy[23:0]);
      csr_write(CSR_CELL_SIZE, cs[23:0]);
      csr_write(CSR_GRID_X, gx[23:0]);
      csr_write(CSR_GRID_Y, gy[23:0]);
      csr_write(CSR_DWELL_STEP, step[23:0]);
      csr_write(CSR_MIN_DWELL, mind[23:0]);
   endtask

   function automatic req_payload_type noise_item();
      logic [95:0] bits;
      req_payload_type r;
      bits = {$urandom, $urandom, $urandom};
      r = bits[$bits(req_payload_type)-1:0];
      return r;
   endfunction

   function automatic void push_item(req_code_type t, longint px, longint py, int cnt,
                                     int idx);
      req_payload_type r;
      r = noise_item();
      r.req_type = t;
      if (t == REQ_POSITION) begin
         r.pos_x = px[23:0];
         r.pos_y = py[23:0];
      end
      if (t == REQ_DETECT) r.cluster_count = cnt[15:0];
      if (t == REQ_READ) r.read_index = idx[11:0];
      pending_req_q = {pending_req_q, r};
   endfunction

   function automatic longint coord_in(longint org, longint c);
      longint cs, v;
      cs = cfg_cell == 0 ? 1 : cfg_cell;
      v = org + c * cs + $urandom_range(cs - 1);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v;
   endfunction

   // Mostly dwell-and-detect visits to cells in or just off the grid, some noise.
   task automatic random_items(int total);
      int done_items, r, k, cx, cy, cells;
      done_items = 0;
      cells = dim_x() * dim_y();
      while (done_items < total) begin
         r = $urandom_range(99);
         if (r < 60) begin
            cx = $urandom_range(dim_x()) - ($urandom_range(9) == 0);
            cy = $urandom_range(dim_y()) - ($urandom_range(9) == 0);
            if ($urandom_range(3) != 0) begin
               if (dim_x() > 0) cx = $urandom_range(dim_x() - 1);
               if (dim_y() > 0) cy = $urandom_range(dim_y() - 1);
            end
            k = $urandom_range(4, 1);
            repeat (k) begin
               push_item(REQ_POSITION, coord_in(org_x, cx), coord_in(org_y, cy), 0, 0);
               done_items++;
               if ($urandom_range(1)) begin
                  push_item(REQ_DETECT, 0, 0,
                            $urandom_range(9) == 0 ? 65535 : $urandom_range(300), 0);
                  done_items++;
               end
            end
         end else if (r < 63) begin
            push_item(REQ_NORMALIZE, 0, 0, 0, 0);
            done_items++;
         end else if (r < 85) begin
            push_item(REQ_READ, 0, 0, 0,
                      ($urandom_range(4) == 0 || cells == 0) ? $urandom_range(4095)
                                                            : $urandom_range(cells - 1));
            done_items++;
         end else begin
            pending_req_q = {pending_req_q, noise_item()};
            done_items++;
         end
      end
   endtask

   initial begin
      int gx, gy;
      foreach (cell_hits[i]) begin
         cell_hits[i] = 0;
         cell_dwell[i] = 0;
         cell_norm[i] = 0;
      end
      cur_x = 0;
      cur_y = 0;
      pos_outside = 1'b1;
      org_x = 0;
      org_y = 0;
      cfg_cell = 256;
      cfg_gx = 64;
      cfg_gy = 64;
      cfg_step = 10;
      cfg_min_dwell = 10;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items at reset settings.
      push_item(REQ_READ, 0, 0, 0, 0);
      push_item(REQ_READ, 0, 0, 0, 4095);
      push_item(REQ_NORMALIZE, 0, 0, 0, 0);
      push_item(REQ_DETECT, 0, 0, 500, 0);
      push_item(REQ_POSITION, 0, 0, 0, 0);
      push_item(REQ_POSITION, 255, 17, 0, 0);
      push_item(REQ_DETECT, 0, 0, 65535, 0);
      push_item(REQ_DETECT, 0, 0, 0, 0);
      push_item(REQ_POSITION, 8388607, 8388607, 0, 0);
      push_item(REQ_DETECT, 0, 0, 77, 0);
      push_item(REQ_POSITION, -8388608, -8388608, 0, 0);
      push_item(REQ_POSITION, -1, 300, 0, 0);
      push_item(REQ_POSITION, 600, 300, 0, 0);
      push_item(REQ_POSITION, 700, 400, 0, 0);
      push_item(REQ_DETECT, 0, 0, 3, 0);
      push_item(REQ_POSITION, 16383, 16383, 0, 0);
      push_item(REQ_POSITION, 16128, 16300, 0, 0);
      push_item(REQ_NORMALIZE, 0, 0, 0, 0);
      push_item(REQ_READ, 0, 0, 0, 0);
      push_item(REQ_READ, 0, 0, 0, 130);
      push_item(REQ_READ, 0, 0, 0, 4095);
      wait_idle();

      // Hit counter saturation in one cell of a small grid, zero minimum dwell.
      set_grid(0, 0, 1, 2, 2, 65535, 0);
      push_item(REQ_POSITION, 1, 1, 0, 0);
      push_item(REQ_POSITION, 1, 1, 0, 0);
      repeat (258) push_item(REQ_DETECT, 0, 0, 65535, 0);
      push_item(REQ_NORMALIZE, 0, 0, 0, 0);
      push_item(REQ_READ, 0, 0, 0, 3);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 45; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 45; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         case (phase)
            0: set_grid(0, 0, 256, 4, 4, 10, 10);
            1: set_grid(-8388608, 8388607 - 3 * 65535, 65535, 3, 4, 1, 65535);
            2: set_grid(-300, 200, 1, 64, 64, 65535, 0);
            3: set_grid(100, -100, 50, 0, 5, 7, 5);
            4: set_grid(-1000, -1000, 40, 100, 2, 13, 26);
            default: begin
               gx = $urandom_range(8, 1);
               gy = $urandom_range(8, 1);
               set_grid($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                        $urandom_range(300, 1), gx, gy, $urandom_range(100, 1),
                        $urandom_range(60));
            end
         endcase
         @(negedge clock);
         random_items(77);
         // The sender holds off mid-phase until every result is back.
         wait_idle();
         random_items(77);
         push_item(REQ_NORMALIZE, 0, 0, 0, 0);
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("tb_dwell_normalized_heatmap_top: done, clean");
      else
         $display("tb_dwell_normalized_heatmap_top: done, errors");
      $finish;
   end

endmodule
